### design/dtm_pkg.sv
// dtm_pkg: shared constants, key-code decode and sine-table math for the DTMF tone mixer.
// No dependencies; imported by dtmf_tone_mixer_unit.
`timescale 1ns / 1ps
`default_nettype none

package dtm_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_SAMPLE_RATE_HZ  = 48000;
    localparam int unsigned DEF_MAX_DIGITS      = 16;
    localparam int unsigned DEF_SINE_TABLE_BITS = 10;
    localparam int unsigned DEF_PHASE_BITS      = 32;

    // Field and port widths
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned KEY_W       = 5;
    localparam int unsigned VOL_W       = 16;
    localparam int unsigned TIMING_W    = 24;
    localparam int unsigned CHAN_W      = 4;
    localparam int unsigned DIGITS_W    = 64;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 64;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_CONT_KEY   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONT_VOL   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQ_VOL    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL     = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BREAK      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGITS     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQ_LENGTH = 4'd7;

    localparam logic [KEY_W-1:0]  KEY_OFF      = 5'd16;
    localparam logic [VOL_W-1:0]  VOL_UNITY    = 16'd16384;
    localparam logic [CHAN_W-1:0] MAX_CHANNELS = 4'd8;

    // DTMF frequencies in Hz
    localparam longint unsigned ROW0_HZ = 697;
    localparam longint unsigned ROW1_HZ = 770;
    localparam longint unsigned ROW2_HZ = 852;
    localparam longint unsigned ROW3_HZ = 941;
    localparam longint unsigned COL0_HZ = 1209;
    localparam longint unsigned COL1_HZ = 1336;
    localparam longint unsigned COL2_HZ = 1477;
    localparam longint unsigned COL3_HZ = 1633;

    // Q30 Taylor coefficients of sin(pi/2 x)
    localparam longint unsigned Q30_C1 = 1686629713;
    localparam longint unsigned Q30_C3 = 693598669;
    localparam longint unsigned Q30_C5 = 85569306;
    localparam longint unsigned Q30_C7 = 5026995;
    localparam longint unsigned Q30_C9 = 172273;

    localparam longint unsigned SINE_PEAK = 32767;

    // Keypad row of a key code (0 is on the bottom row with star and hash)
    function automatic logic [1:0] key_row(input logic [3:0] code);
        logic [1:0] r;
        unique case (code)
            4'd1, 4'd2, 4'd3, 4'd12: r = 2'd0;
            4'd4, 4'd5, 4'd6, 4'd13: r = 2'd1;
            4'd7, 4'd8, 4'd9, 4'd14: r = 2'd2;
            default:                 r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] key_col(input logic [3:0] code);
        logic [1:0] c;
        unique case (code)
            4'd1, 4'd4, 4'd7, 4'd10: c = 2'd0;
            4'd0, 4'd2, 4'd5, 4'd8:  c = 2'd1;
            4'd3, 4'd6, 4'd9, 4'd11: c = 2'd2;
            default:                 c = 2'd3;
        endcase
        return c;
    endfunction

    // Quarter-wave magnitude at position u of a 2^(tb-2) step quarter.
    // Evaluated on constant arguments only, so it folds at elaboration.
    function automatic logic [SAMPLE_W-2:0] quarter_sine(input int unsigned u,
                                                        input int unsigned tb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned r;
        longint unsigned m;
        x  = longint'(u) << (18 - tb);
        x2 = (x * x) >> 16;
        t  = Q30_C9;
        t  = Q30_C7 - ((x2 * t) >> 16);
        t  = Q30_C5 - ((x2 * t) >> 16);
        t  = Q30_C3 - ((x2 * t) >> 16);
        t  = Q30_C1 - ((x2 * t) >> 16);
        r  = (x * t) >> 16;
        m  = (r * SINE_PEAK + (longint'(1) << 29)) >> 30;
        if (m > SINE_PEAK) begin
            m = SINE_PEAK;
        end
        return 15'(m);
    endfunction

    // Clamp a widened sum to signed 16 bits
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
        logic signed [SAMPLE_W-1:0] s;
        if (v > 20'sd32767) begin
            s = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            s = 16'sh8000;
        end else begin
            s = v[SAMPLE_W-1:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### design/dtmf_tone_mixer_unit.sv
// dtmf_tone_mixer_unit: top level of the DTMF tone mixer, sine lookup, scaling and mixing.
// Depends on dtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Mixes DTMF dual tones into an interleaved stream of signed 16-bit samples.
// Each input beat on s_* is one channel's sample; channel_count consecutive
// beats form a frame and share one tone value. Two tones can sound at once:
// a continuous key (register 0, code 16 = off) and a programmed sequence of
// up to MAX_DIGITS key codes (registers 3..7). Each sequence digit sounds
// for signal_samples frames and is silent for break_samples frames; writing
// sequence_length (re)starts playback. The continuous tone is added first
// with 16-bit saturation, then the sequence tone with saturation again.
// m_sequence_busy tells whether the beat fell inside a playing sequence.
// Throughput is one beat per clock while m_ready does not hold the output off;
// each beat passes three register stages (sine lookup, gain multiply, round
// and saturate). Tone state (phase accumulators, digit counters)
// advances at the input handshake, so back-pressure on m_* only stalls the
// stages. Sine values come from a constant quarter-wave table of
// 2^(SINE_TABLE_BITS-2)+1 entries, read at four phases per beat.
// Configuration beats on cfg_* are always taken (cfg_ready is tied high) and
// must only be issued while no sample is in flight.

module dtmf_tone_mixer_unit #(
    parameter int unsigned SAMPLE_RATE_HZ  = dtm_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int unsigned MAX_DIGITS      = dtm_pkg::DEF_MAX_DIGITS,
    parameter int unsigned SINE_TABLE_BITS = dtm_pkg::DEF_SINE_TABLE_BITS,
    parameter int unsigned PHASE_BITS      = dtm_pkg::DEF_PHASE_BITS
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // sample input
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  signed [dtm_pkg::SAMPLE_W-1:0]   s_sample_in,
    // mixed output
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic signed [dtm_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic                                  m_sequence_busy,
    // register writes
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire         [dtm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire         [dtm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dtm_pkg::*;

    // ---------------------------------------------------------------
    // Derived constants
    // ---------------------------------------------------------------
    localparam int unsigned QBITS = SINE_TABLE_BITS - 2;       // bits within a quadrant
    localparam int unsigned QN    = 1 << QBITS;                // steps per quadrant
    localparam int unsigned QW    = QBITS + 1;                 // table address width
    localparam longint unsigned HALF_RATE = SAMPLE_RATE_HZ / 2;
    localparam int unsigned DIGIT_W = $clog2(DIGITS_W / 4);

    // phase increment = round(f * 2^PHASE_BITS / rate)
    localparam logic [PHASE_BITS-1:0] STEP_R0 =
        PHASE_BITS'(((ROW0_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);
    localparam logic [PHASE_BITS-1:0] STEP_R1 =
        PHASE_BITS'(((ROW1_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);
    localparam logic [PHASE_BITS-1:0] STEP_R2 =
        PHASE_BITS'(((ROW2_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);
    localparam logic [PHASE_BITS-1:0] STEP_R3 =
        PHASE_BITS'(((ROW3_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);
    localparam logic [PHASE_BITS-1:0] STEP_C0 =
        PHASE_BITS'(((COL0_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);
    localparam logic [PHASE_BITS-1:0] STEP_C1 =
        PHASE_BITS'(((COL1_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);
    localparam logic [PHASE_BITS-1:0] STEP_C2 =
        PHASE_BITS'(((COL2_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);
    localparam logic [PHASE_BITS-1:0] STEP_C3 =
        PHASE_BITS'(((COL3_HZ << PHASE_BITS) + HALF_RATE) / SAMPLE_RATE_HZ);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DIGITS);

    // ---------------------------------------------------------------
    // Quarter-wave sine table (constant, folded at elaboration)
    // ---------------------------------------------------------------
    logic [SAMPLE_W-2:0] qtab [QN+1];

    for (genvar gi = 0; gi <= QN; gi++) begin : g_qtab
        assign qtab[gi] = quarter_sine(gi, SINE_TABLE_BITS);
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [KEY_W-1:0]    cont_key_reg;
    logic [VOL_W-1:0]    cont_vol_reg;
    logic [VOL_W-1:0]    seq_vol_reg;
    logic [TIMING_W-1:0] signal_reg;
    logic [TIMING_W-1:0] break_reg;
    logic [CHAN_W-1:0]   channels_reg;
    logic [DIGITS_W-1:0] digits_reg;
    logic [LEN_W-1:0]    seq_len_reg;

    // ---------------------------------------------------------------
    // Tone state
    // ---------------------------------------------------------------
    logic [PHASE_BITS-1:0] cont_lo_reg, cont_hi_reg;
    logic [PHASE_BITS-1:0] seq_lo_reg, seq_hi_reg;
    logic [2:0]            chan_idx_reg;
    logic [LEN_W-1:0]      digit_idx_reg;
    logic [TIMING_W:0]     frames_reg;
    logic                  seq_active_reg;

    // ---------------------------------------------------------------
    // Pipeline registers
    // ---------------------------------------------------------------
    logic                       v1_reg, v2_reg, mv_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg, s2_x_reg;
    logic signed [SAMPLE_W:0]   s1_csum_reg, s1_ssum_reg;
    logic                       s1_busy_reg, s2_busy_reg;
    logic [2*VOL_W-1:0]         s2_cprod_reg, s2_sprod_reg;
    logic                       s2_cneg_reg, s2_sneg_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_busy_reg;

    // ---------------------------------------------------------------
    // Handshake: one beat per stage, ready ripples back
    // ---------------------------------------------------------------
    logic adv3, adv2, adv1;
    logic in_acc;

    assign adv3    = !mv_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign in_acc  = s_valid && adv1;

    assign cfg_ready       = 1'b1;
    assign m_valid         = mv_reg;
    assign m_sample_out    = out_sample_reg;
    assign m_sequence_busy = out_busy_reg;

    // ---------------------------------------------------------------
    // Frame / sequence decode
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0]   chans_eff;
    logic                frame_end;
    logic                cont_on;
    logic                sounding;
    logic [3:0]          cont_code, seq_code;
    logic [TIMING_W:0]   digit_total;
    logic [TIMING_W+1:0] frames_inc;
    logic                digit_done;
    logic [LEN_W-1:0]    digit_idx_inc;

    always_comb begin
        // channel count 0 acts as 1, above 8 acts as 8
        if (channels_reg == '0) begin
            chans_eff = CHAN_W'(1);
        end else if (channels_reg > MAX_CHANNELS) begin
            chans_eff = MAX_CHANNELS;
        end else begin
            chans_eff = channels_reg;
        end
        frame_end     = ({1'b0, chan_idx_reg} + CHAN_W'(1)) >= chans_eff;
        cont_on       = cont_key_reg < KEY_OFF;
        cont_code     = cont_key_reg[3:0];
        sounding      = seq_active_reg && (frames_reg < {1'b0, signal_reg});
        seq_code      = digits_reg[digit_idx_reg[DIGIT_W-1:0]*4 +: 4];
        digit_total   = {1'b0, signal_reg} + {1'b0, break_reg};
        frames_inc    = {1'b0, frames_reg} + (TIMING_W+2)'(1);
        digit_done    = frames_inc >= {1'b0, digit_total};
        digit_idx_inc = digit_idx_reg + LEN_W'(1);
    end

    // phase increments for the current codes
    logic [PHASE_BITS-1:0] row_step [4];
    logic [PHASE_BITS-1:0] col_step [4];
    logic [PHASE_BITS-1:0] cont_lo_step, cont_hi_step, seq_lo_step, seq_hi_step;

    assign row_step = '{STEP_R0, STEP_R1, STEP_R2, STEP_R3};
    assign col_step = '{STEP_C0, STEP_C1, STEP_C2, STEP_C3};

    assign cont_lo_step = row_step[key_row(cont_code)];
    assign cont_hi_step = col_step[key_col(cont_code)];
    assign seq_lo_step  = row_step[key_row(seq_code)];
    assign seq_hi_step  = col_step[key_col(seq_code)];

    // ---------------------------------------------------------------
    // Sine lookup at the four phases (stage 1 input)
    // ---------------------------------------------------------------
    logic [PHASE_BITS-1:0]      ph [4];
    logic [QW-1:0]              taddr [4];
    logic signed [SAMPLE_W-1:0] sine [4];
    logic [QBITS-1:0]           qpos;
    logic signed [SAMPLE_W:0]   csum_next, ssum_next;

    assign ph = '{cont_lo_reg, cont_hi_reg, seq_lo_reg, seq_hi_reg};

    always_comb begin
        qpos = '0;
        for (int i = 0; i < 4; i++) begin
            // quadrant in the top two phase bits; odd quadrants mirror
            qpos = ph[i][PHASE_BITS-3 -: QBITS];
            if (ph[i][PHASE_BITS-2]) begin
                taddr[i] = QW'(QN) - {1'b0, qpos};
            end else begin
                taddr[i] = {1'b0, qpos};
            end
            if (ph[i][PHASE_BITS-1]) begin
                sine[i] = -$signed({1'b0, qtab[taddr[i]]});
            end else begin
                sine[i] = $signed({1'b0, qtab[taddr[i]]});
            end
        end
        csum_next = cont_on  ? ({sine[0][SAMPLE_W-1], sine[0]} + {sine[1][SAMPLE_W-1], sine[1]})
                             : '0;
        ssum_next = sounding ? ({sine[2][SAMPLE_W-1], sine[2]} + {sine[3][SAMPLE_W-1], sine[3]})
                             : '0;
    end

    // ---------------------------------------------------------------
    // Gain multiply (stage 2 input)
    // ---------------------------------------------------------------
    logic [SAMPLE_W:0]   cabs_full, sabs_full;
    logic [2*VOL_W-1:0]  cprod_next, sprod_next;

    always_comb begin
        cabs_full  = s1_csum_reg[SAMPLE_W] ? 17'(-s1_csum_reg) : 17'(s1_csum_reg);
        sabs_full  = s1_ssum_reg[SAMPLE_W] ? 17'(-s1_ssum_reg) : 17'(s1_ssum_reg);
        // |sum| <= 65534, fits 16 bits
        cprod_next = cabs_full[SAMPLE_W-1:0] * cont_vol_reg;
        sprod_next = sabs_full[SAMPLE_W-1:0] * seq_vol_reg;
    end

    // ---------------------------------------------------------------
    // Round half away from zero, mix, saturate (stage 3 input)
    // ---------------------------------------------------------------
    logic [2*VOL_W:0]         crnd, srnd;
    logic signed [18:0]       ctone, stone;
    logic signed [19:0]       mix1, mix2;
    logic signed [SAMPLE_W-1:0] y1, y_next;

    always_comb begin
        crnd   = {1'b0, s2_cprod_reg} + 33'd16384;
        srnd   = {1'b0, s2_sprod_reg} + 33'd16384;
        ctone  = s2_cneg_reg ? -$signed({1'b0, crnd[2*VOL_W:15]})
                             :  $signed({1'b0, crnd[2*VOL_W:15]});
        stone  = s2_sneg_reg ? -$signed({1'b0, srnd[2*VOL_W:15]})
                             :  $signed({1'b0, srnd[2*VOL_W:15]});
        mix1   = {{4{s2_x_reg[SAMPLE_W-1]}}, s2_x_reg} + {ctone[18], ctone};
        y1     = sat16(mix1);
        mix2   = {{4{y1[SAMPLE_W-1]}}, y1} + {stone[18], stone};
        y_next = sat16(mix2);
    end

    // ---------------------------------------------------------------
    // Pipeline stages
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                mv_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_x_reg    <= s_sample_in;
            s1_csum_reg <= csum_next;
            s1_ssum_reg <= ssum_next;
            s1_busy_reg <= seq_active_reg;
        end
        if (v1_reg && adv2) begin
            s2_x_reg     <= s1_x_reg;
            s2_cprod_reg <= cprod_next;
            s2_sprod_reg <= sprod_next;
            s2_cneg_reg  <= s1_csum_reg[SAMPLE_W];
            s2_sneg_reg  <= s1_ssum_reg[SAMPLE_W];
            s2_busy_reg  <= s1_busy_reg;
        end
        if (v2_reg && adv3) begin
            out_sample_reg <= y_next;
            out_busy_reg   <= s2_busy_reg;
        end
    end

    // ---------------------------------------------------------------
    // Register writes and tone state update
    // ---------------------------------------------------------------
    logic [LEN_W-1:0] len_next;

    assign len_next = (cfg_data[LEN_W-1:0] > LEN_MAX) ? LEN_MAX : cfg_data[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cont_key_reg   <= KEY_OFF;
            cont_vol_reg   <= VOL_UNITY;
            seq_vol_reg    <= VOL_UNITY;
            signal_reg     <= '0;
            break_reg      <= '0;
            channels_reg   <= CHAN_W'(1);
            digits_reg     <= '0;
            seq_len_reg    <= '0;
            cont_lo_reg    <= '0;
            cont_hi_reg    <= '0;
            seq_lo_reg     <= '0;
            seq_hi_reg     <= '0;
            chan_idx_reg   <= '0;
            digit_idx_reg  <= '0;
            frames_reg     <= '0;
            seq_active_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CONT_KEY: begin
                    cont_key_reg <= cfg_data[KEY_W-1:0];
                    cont_lo_reg  <= '0;
                    cont_hi_reg  <= '0;
                end
                REG_CONT_VOL: begin
                    cont_vol_reg <= cfg_data[VOL_W-1:0];
                end
                REG_SEQ_VOL: begin
                    seq_vol_reg <= cfg_data[VOL_W-1:0];
                end
                REG_SIGNAL: begin
                    signal_reg <= cfg_data[TIMING_W-1:0];
                end
                REG_BREAK: begin
                    break_reg <= cfg_data[TIMING_W-1:0];
                end
                REG_CHANNELS: begin
                    channels_reg <= cfg_data[CHAN_W-1:0];
                end
                REG_DIGITS: begin
                    digits_reg <= cfg_data;
                end
                REG_SEQ_LENGTH: begin
                    // restart from digit zero; stays idle if nothing to play
                    seq_len_reg    <= len_next;
                    digit_idx_reg  <= '0;
                    frames_reg     <= '0;
                    seq_lo_reg     <= '0;
                    seq_hi_reg     <= '0;
                    seq_active_reg <= (len_next != '0) && (signal_reg != '0);
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            if (!frame_end) begin
                chan_idx_reg <= chan_idx_reg + 3'd1;
            end else begin
                chan_idx_reg <= '0;
                if (cont_on) begin
                    cont_lo_reg <= cont_lo_reg + cont_lo_step;
                    cont_hi_reg <= cont_hi_reg + cont_hi_step;
                end
                if (seq_active_reg) begin
                    if (digit_done) begin
                        // next digit restarts its phases
                        frames_reg    <= '0;
                        seq_lo_reg    <= '0;
                        seq_hi_reg    <= '0;
                        digit_idx_reg <= digit_idx_inc;
                        if (digit_idx_inc >= seq_len_reg) begin
                            seq_active_reg <= 1'b0;
                        end
                    end else begin
                        frames_reg <= frames_inc[TIMING_W:0];
                        if (sounding) begin
                            seq_lo_reg <= seq_lo_reg + seq_lo_step;
                            seq_hi_reg <= seq_hi_reg + seq_hi_step;
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a playing sequence always points at a digit inside its length
    a_digit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_active_reg |-> (digit_idx_reg < seq_len_reg))
        else $error("sequence digit index past sequence length");

    // an idle sequence leaves its counters and phases cleared
    a_seq_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !seq_active_reg |-> (frames_reg == '0 && seq_lo_reg == '0 && seq_hi_reg == '0))
        else $error("idle sequence with stale frame count or phase");

    // continuous key off keeps its phases at zero
    a_cont_off_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !cont_on |-> (cont_lo_reg == '0 && cont_hi_reg == '0))
        else $error("continuous phases moved while key is off");

    // an accepted beat occupies the first stage on the next cycle
    a_stage1_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> v1_reg)
        else $error("accepted beat lost before stage one");

endmodule

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for dtmf_tone_mixer_unit, with directed table, random phases
// and an in-bench predictor of the tone mixing. Depends on dtm_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
    import dtm_pkg::*;

    // Unused register index; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'd15;

    // Quarter-wave polynomial coefficients of sin(pi/2 x), Q30
    localparam longint unsigned SIN_K1 = 64'd1686629713;
    localparam longint unsigned SIN_K3 = 64'd693598669;
    localparam longint unsigned SIN_K5 = 64'd85569306;
    localparam longint unsigned SIN_K7 = 64'd5026995;
    localparam longint unsigned SIN_K9 = 64'd172273;
    localparam longint unsigned RATE_HZ = 64'd48000;
    localparam int SEQ_DIGITS_MAX = 16;
    localparam int RANDOM_BEATS = 750;
    localparam int HOLD_CYCLES = 400;

    // ---------------------------------------------------------------- DUT
    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    wire                           s_ready;
    logic signed [SAMPLE_W-1:0]    s_sample_in = '0;
    wire                           m_valid;
    logic                          m_ready = 1'b0;
    wire signed [SAMPLE_W-1:0]     m_sample_out;
    wire                           m_sequence_busy;
    logic                          cfg_valid = 1'b0;
    wire                           cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    dtmf_tone_mixer_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_in     (s_sample_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out),
        .m_sequence_busy (m_sequence_busy),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #1000000;
        $display("tb NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- predictor state
    // Register copies, as the mixer sees them
    logic [KEY_W-1:0]    key_q;
    logic [VOL_W-1:0]    key_gain_q;
    logic [VOL_W-1:0]    seq_gain_q;
    logic [TIMING_W-1:0] signal_q;
    logic [TIMING_W-1:0] break_q;
    logic [CHAN_W-1:0]   chans_q;
    logic [DIGITS_W-1:0] digits_q;
    logic [LEN_W-1:0]    len_q;
    // Tone state
    logic [31:0]         key_ph_row, key_ph_col;
    logic [31:0]         seq_ph_row, seq_ph_col;
    logic [2:0]          chan_pos;
    int                  digit_pos;
    int                  digit_frames;
    logic                seq_on;

    // One expected output beat; tag is the input beat number it belongs to
    typedef struct packed {
        int unsigned       tag;
        logic [SAMPLE_W-1:0] sample;
        logic              busy;
    } mix_exp_t;

    mix_exp_t    mixed_q[$];      // expected mixed beats, oldest first
    mix_exp_t    literal_q[$];    // hand-written expectations of the directed rows

    // Directed table row: either a register write or an input beat
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_W-1:0]   smp;
        logic                  known;
        logic [SAMPLE_W-1:0]   want;
        logic                  want_busy;
    } plan_row_t;

    plan_row_t   directed_tbl[$];

    int unsigned beats_issued = 0;
    int unsigned beats_taken = 0;
    int          results_seen = 0;
    int          busy_seen = 0;
    int          sat_seen = 0;
    int          cfg_writes = 0;
    int          errors = 0;
    int          hold_req = 0;
    int          holds_done = 0;
    logic        calm = 1'b0;     // no random idling on either side while set

    // ---------------------------------------------------------------- tone math
    function automatic int unsigned row_hz(input logic [3:0] c);
        case (c)
            4'd1, 4'd2, 4'd3, 4'd12: return 697;
            4'd4, 4'd5, 4'd6, 4'd13: return 770;
            4'd7, 4'd8, 4'd9, 4'd14: return 852;
            default:                 return 941;
        endcase
    endfunction

    function automatic int unsigned col_hz(input logic [3:0] c);
        case (c)
            4'd1, 4'd4, 4'd7, 4'd10: return 1209;
            4'd0, 4'd2, 4'd5, 4'd8:  return 1336;
            4'd3, 4'd6, 4'd9, 4'd11: return 1477;
            default:                 return 1633;
        endcase
    endfunction

    // round(f * 2^32 / rate)
    function automatic logic [31:0] phase_inc(input int unsigned hz);
        longint unsigned num;
        num = hz;
        num = ((num << 32) + (RATE_HZ / 2)) / RATE_HZ;
        return num[31:0];
    endfunction

    // Sine table entry at the top 10 bits of a phase
    function automatic int tone_sine(input logic [31:0] ph);
        logic [9:0]      k;
        longint unsigned x, x2, t, r, m;
        k = ph[31:22];
        x = {48'd0, k[7:0], 8'd0};
        if (k[8]) begin
            x = 64'd65536 - x;          // mirrored quarter
        end
        x2 = (x * x) >> 16;
        t  = SIN_K9;
        t  = SIN_K7 - ((x2 * t) >> 16);
        t  = SIN_K5 - ((x2 * t) >> 16);
        t  = SIN_K3 - ((x2 * t) >> 16);
        t  = SIN_K1 - ((x2 * t) >> 16);
        r  = (x * t) >> 16;
        m  = (r * 64'd32767 + (64'd1 << 29)) >> 30;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return k[9] ? -int'(m[15:0]) : int'(m[15:0]);
    endfunction

    // (s1 + s2) * gain / 32768, rounded half away from zero
    function automatic int tone_level(input logic [31:0] p_row, input logic [31:0] p_col,
                                      input logic [VOL_W-1:0] gain);
        int              sum;
        longint unsigned mag;
        int              q;
        sum = tone_sine(p_row) + tone_sine(p_col);
        mag = (sum < 0) ? -sum : sum;
        mag = (mag * gain + 64'd16384) >> 15;
        q = int'(mag);
        return (sum < 0) ? -q : q;
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Mix one input beat and advance the tone state
    task automatic predict_mix(input logic signed [SAMPLE_W-1:0] smp,
                               output logic [SAMPLE_W-1:0] y, output logic busy);
        int         chans, key_tone, seq_tone, acc, total;
        logic       frame_end, sounding;
        logic [3:0] code;
        chans = (chans_q == 0) ? 1 : ((chans_q > MAX_CHANNELS) ? 8 : int'(chans_q));
        frame_end = (int'(chan_pos) + 1) >= chans;
        busy = seq_on;
        sounding = seq_on && (digit_frames < int'(signal_q));
        code = digits_q[{digit_pos[3:0], 2'b00} +: 4];
        key_tone = (key_q < KEY_OFF) ? tone_level(key_ph_row, key_ph_col, key_gain_q) : 0;
        seq_tone = sounding ? tone_level(seq_ph_row, seq_ph_col, seq_gain_q) : 0;
        // key tone saturates first, sequence tone on top of that
        acc = clamp16(clamp16(int'(smp) + key_tone) + seq_tone);
        y = acc[SAMPLE_W-1:0];

        if (frame_end) begin
            chan_pos = 3'd0;
            if (key_q < KEY_OFF) begin
                key_ph_row = key_ph_row + phase_inc(row_hz(key_q[3:0]));
                key_ph_col = key_ph_col + phase_inc(col_hz(key_q[3:0]));
            end
            if (seq_on) begin
                total = int'(signal_q) + int'(break_q);
                if (sounding) begin
                    seq_ph_row = seq_ph_row + phase_inc(row_hz(code));
                    seq_ph_col = seq_ph_col + phase_inc(col_hz(code));
                end
                if (digit_frames + 1 >= total) begin
                    // next digit restarts its phases
                    digit_frames = 0;
                    seq_ph_row = '0;
                    seq_ph_col = '0;
                    digit_pos++;
                    if (digit_pos >= int'(len_q)) begin
                        seq_on = 1'b0;
                    end
                end else begin
                    digit_frames++;
                end
            end
        end else begin
            chan_pos = chan_pos + 3'd1;
        end
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_CONT_KEY: begin
                key_q = v[KEY_W-1:0];
                key_ph_row = '0;        // any key write restarts the key tone
                key_ph_col = '0;
            end
            REG_CONT_VOL:   key_gain_q = v[VOL_W-1:0];
            REG_SEQ_VOL:    seq_gain_q = v[VOL_W-1:0];
            REG_SIGNAL:     signal_q = v[TIMING_W-1:0];
            REG_BREAK:      break_q = v[TIMING_W-1:0];
            REG_CHANNELS:   chans_q = v[CHAN_W-1:0];
            REG_DIGITS:     digits_q = v;
            REG_SEQ_LENGTH: begin
                len_q = v[LEN_W-1:0];
                if (len_q > SEQ_DIGITS_MAX) begin
                    len_q = LEN_W'(SEQ_DIGITS_MAX);
                end
                digit_pos = 0;
                digit_frames = 0;
                seq_ph_row = '0;
                seq_ph_col = '0;
                seq_on = (len_q != 0) && (signal_q != 0);
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- scoreboard
    // Everything is sampled at the rising edge, before the NBA updates of that edge.
    always @(posedge aclk) begin : scoreboard
        mix_exp_t            e;
        logic [SAMPLE_W-1:0] y;
        logic                b;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (mixed_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("output beat with nothing expected: sample_out %0d busy %0b",
                                 m_sample_out, m_sequence_busy);
                    end
                end else begin
                    e = mixed_q.pop_front();
                    results_seen++;
                    if (m_sample_out !== e.sample || m_sequence_busy !== e.busy) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch on beat %0d: sample_out exp %0d got %0d, busy exp %0b got %0b",
                                     e.tag, $signed(e.sample), m_sample_out, e.busy,
                                     m_sequence_busy);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_mix(s_sample_in, y, b);
                if (literal_q.size() != 0 && literal_q[0].tag == beats_taken) begin
                    e = literal_q.pop_front();
                end else begin
                    e.tag = beats_taken;
                    e.sample = y;
                    e.busy = b;
                end
                if (e.busy) busy_seen++;
                if (e.sample == 16'h7FFF || e.sample == 16'h8000) sat_seen++;
                mixed_q.push_back(e);
                beats_taken++;
            end
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    // Mostly no gap, often a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return 64'hFFFF;
            2:       return 64'(VOL_UNITY);
            default: return 64'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one sample beat; returns at the edge that takes it, valid still high
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= smp;
        beats_issued++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every expected beat is out
    task automatic settle();
        s_valid <= 1'b0;
        while (mixed_q.size() != 0 || beats_taken != beats_issued) @(posedge aclk);
        repeat (4) @(posedge aclk);   // pipeline is three stages deep
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge aclk);
    endtask

    function automatic plan_row_t mk_reg(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] v);
        plan_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.idx = idx;
        r.data = v;
        return r;
    endfunction

    function automatic plan_row_t mk_beat(input logic [SAMPLE_W-1:0] smp);
        plan_row_t r;
        r = '0;
        r.smp = smp;
        return r;
    endfunction

    function automatic plan_row_t mk_known(input logic [SAMPLE_W-1:0] smp,
                                           input logic [SAMPLE_W-1:0] want, input logic busy);
        plan_row_t r;
        r = '0;
        r.smp = smp;
        r.known = 1'b1;
        r.want = want;
        r.want_busy = busy;
        return r;
    endfunction

    // ---------------------------------------------------------------- receiver
    // Ready in random stretches; a hold request drops ready for that many cycles.
    initial begin : receiver
        int n;
        @(posedge aclk);
        forever begin
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
                holds_done++;
            end else if (calm || $urandom_range(0, 1) == 1) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (idle_len() + 1) @(posedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------- main sequence
    initial begin : main_seq
        plan_row_t row;
        mix_exp_t  lit;
        int        phase_no;
        int        rand_beats;
        int        n;
        int        mode;

        // predictor in its reset state
        key_q = KEY_OFF;
        key_gain_q = VOL_UNITY;
        seq_gain_q = VOL_UNITY;
        signal_q = '0;
        break_q = '0;
        chans_q = CHAN_W'(1);
        digits_q = '0;
        len_q = '0;
        key_ph_row = '0;
        key_ph_col = '0;
        seq_ph_row = '0;
        seq_ph_col = '0;
        chan_pos = '0;
        digit_pos = 0;
        digit_frames = 0;
        seq_on = 1'b0;

        // Directed table. Rows with a written expectation are checked against it,
        // all others against the predictor.
        // out of reset: key off, no sequence, samples pass through untouched
        directed_tbl.push_back(mk_known(16'h0000, 16'h0000, 1'b0));
        directed_tbl.push_back(mk_known(16'h7FFF, 16'h7FFF, 1'b0));
        directed_tbl.push_back(mk_known(16'h8000, 16'h8000, 1'b0));
        directed_tbl.push_back(mk_known(16'hFFFF, 16'hFFFF, 1'b0));
        // key tone at full gain against the sample extremes
        directed_tbl.push_back(mk_reg(REG_CONT_KEY, 64'd5));
        directed_tbl.push_back(mk_reg(REG_CONT_VOL, 64'hFFFF));
        directed_tbl.push_back(mk_beat(16'h7FFF));
        directed_tbl.push_back(mk_beat(16'h8000));
        directed_tbl.push_back(mk_beat(16'h0000));
        directed_tbl.push_back(mk_beat(16'h1234));
        // key codes past 16 are off too
        directed_tbl.push_back(mk_reg(REG_CONT_KEY, 64'd20));
        directed_tbl.push_back(mk_known(16'd100, 16'd100, 1'b0));
        // zero gain mutes a running key tone
        directed_tbl.push_back(mk_reg(REG_CONT_VOL, 64'd0));
        directed_tbl.push_back(mk_reg(REG_CONT_KEY, 64'd11));
        directed_tbl.push_back(mk_known(16'd7, 16'd7, 1'b0));
        directed_tbl.push_back(mk_known(16'hFFF9, 16'hFFF9, 1'b0));
        // channel count 0 acts as 1, above 8 acts as 8
        directed_tbl.push_back(mk_reg(REG_CONT_VOL, 64'(VOL_UNITY)));
        directed_tbl.push_back(mk_reg(REG_CHANNELS, 64'd0));
        directed_tbl.push_back(mk_beat(16'h0100));
        directed_tbl.push_back(mk_beat(16'hFF00));
        directed_tbl.push_back(mk_reg(REG_CHANNELS, 64'd12));
        directed_tbl.push_back(mk_beat(16'h0000));
        directed_tbl.push_back(mk_beat(16'h4000));
        directed_tbl.push_back(mk_beat(16'hC000));
        // short digit sequence, all sixteen codes packed, length past 16 clamps
        directed_tbl.push_back(mk_reg(REG_CHANNELS, 64'd1));
        directed_tbl.push_back(mk_reg(REG_CONT_KEY, 64'(KEY_OFF)));
        directed_tbl.push_back(mk_reg(REG_SEQ_VOL, 64'hFFFF));
        directed_tbl.push_back(mk_reg(REG_SIGNAL, 64'd2));
        directed_tbl.push_back(mk_reg(REG_BREAK, 64'd1));
        directed_tbl.push_back(mk_reg(REG_DIGITS, 64'hFEDC_BA98_7654_3210));
        directed_tbl.push_back(mk_reg(REG_SEQ_LENGTH, 64'd20));
        directed_tbl.push_back(mk_beat(16'h0000));
        directed_tbl.push_back(mk_beat(16'h7FFF));
        directed_tbl.push_back(mk_beat(16'h8000));
        directed_tbl.push_back(mk_beat(16'h0000));
        // signal_samples zero: a length write leaves the sequence idle
        directed_tbl.push_back(mk_reg(REG_SIGNAL, 64'd0));
        directed_tbl.push_back(mk_reg(REG_SEQ_LENGTH, 64'd3));
        directed_tbl.push_back(mk_known(16'd9, 16'd9, 1'b0));
        // zero sequence gain: silent, but still busy
        directed_tbl.push_back(mk_reg(REG_SEQ_VOL, 64'd0));
        directed_tbl.push_back(mk_reg(REG_SIGNAL, 64'd4));
        directed_tbl.push_back(mk_reg(REG_SEQ_LENGTH, 64'd1));
        directed_tbl.push_back(mk_known(16'd50, 16'd50, 1'b1));
        directed_tbl.push_back(mk_known(16'hFFCE, 16'hFFCE, 1'b1));

        // hold synchronous reset, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_tbl[i]) begin
            row = directed_tbl[i];
            if (row.is_reg) begin
                settle();           // registers only change with the pipe empty
                write_reg(row.idx, row.data);
            end else begin
                if (row.known) begin
                    lit.tag = beats_issued;
                    lit.sample = row.want;
                    lit.busy = row.want_busy;
                    literal_q.push_back(lit);
                end
                push_sample(row.smp);
            end
        end

        // Random phases: new register settings between phases, then a burst of
        // beats. Most phases restart a short, well-formed digit sequence.
        phase_no = 0;
        rand_beats = 0;
        while (rand_beats < RANDOM_BEATS) begin
            settle();
            phase_no++;
            calm = (phase_no % 5 == 2);
            mode = $urandom_range(0, 9);

            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_CHANNELS, 64'd0);
                    1:       write_reg(REG_CHANNELS, 64'($urandom_range(9, 15)));
                    2, 3, 4: write_reg(REG_CHANNELS, 64'($urandom_range(3, 8)));
                    default: write_reg(REG_CHANNELS, 64'($urandom_range(1, 2)));
                endcase
            end
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 9) < 8) begin
                    write_reg(REG_CONT_KEY, 64'($urandom_range(0, 15)));
                end else begin
                    write_reg(REG_CONT_KEY, 64'($urandom_range(16, 31)));
                end
            end
            if ($urandom_range(0, 2) == 0) write_reg(REG_CONT_VOL, pick_gain());
            if ($urandom_range(0, 2) == 0) write_reg(REG_SEQ_VOL, pick_gain());

            case (mode)
                6: begin
                    // timing and digits change under a running sequence, no restart
                    write_reg(REG_SIGNAL, 64'($urandom_range(1, 8)));
                    write_reg(REG_BREAK, 64'($urandom_range(0, 6)));
                    write_reg(REG_DIGITS, {$urandom, $urandom});
                end
                7: begin
                    // longest signal or longest break
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(REG_SIGNAL, 64'hFF_FFFF);
                        write_reg(REG_BREAK, 64'($urandom_range(0, 6)));
                    end else begin
                        write_reg(REG_SIGNAL, 64'($urandom_range(1, 3)));
                        write_reg(REG_BREAK, 64'hFF_FFFF);
                    end
                    write_reg(REG_SEQ_LENGTH, 64'($urandom_range(1, 16)));
                end
                8: begin
                    // length zero, or past the digit count
                    write_reg(REG_SIGNAL, 64'($urandom_range(0, 8)));
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(REG_SEQ_LENGTH, 64'd0);
                    end else begin
                        write_reg(REG_SEQ_LENGTH, 64'($urandom_range(17, 31)));
                    end
                end
                9: begin
                    write_reg(REG_SPARE, {$urandom, $urandom});
                    write_reg(REG_DIGITS, {$urandom, $urandom});
                end
                default: begin
                    write_reg(REG_SIGNAL, 64'($urandom_range(1, 8)));
                    write_reg(REG_BREAK, 64'($urandom_range(0, 6)));
                    write_reg(REG_DIGITS, {$urandom, $urandom});
                    write_reg(REG_SEQ_LENGTH, 64'($urandom_range(1, 16)));
                end
            endcase

            if (phase_no == 4) begin
                // back-pressure: output held off while the input keeps offering
                calm = 1'b1;
                hold_req = HOLD_CYCLES;
                while (hold_req != 0) @(posedge aclk);
                n = 80;
            end else begin
                n = $urandom_range(15, 50);
            end

            repeat (n) begin
                case ($urandom_range(0, 9))
                    0:       push_sample(16'h7FFF);
                    1:       push_sample(16'h8000);
                    2:       push_sample(16'($signed($urandom_range(0, 32)) - 16));
                    default: push_sample(16'($urandom));
                endcase
                rand_beats++;
            end
        end
        calm = 1'b0;

        // drain, then watch a while for stray output beats
        settle();
        repeat (20) @(posedge aclk);

        $display("covered %0d beats (%0d random in %0d phases), %0d register writes, %0d holds",
                 beats_taken, rand_beats, phase_no, cfg_writes, holds_done);
        $display("%0d beats checked, %0d inside a sequence, %0d saturated, %0d mismatches",
                 results_seen, busy_seen, sat_seen, errors);
        if (errors == 0 && mixed_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### dtmf_tone_mixer_unit.f
design/dtm_pkg.sv
design/dtmf_tone_mixer_unit.sv
bench/tb.sv
